>>> sv/marea_pkg.sv
// ----------------------------------------------------------------------------
// marea_pkg
// Shared constants, types and state codes for the minimum-area rectangle block.
// ----------------------------------------------------------------------------
package marea_pkg;

	localparam int MAX_POINTS = 256;
	localparam int IDX_W      = $clog2(MAX_POINTS);
	localparam int CNT_W      = IDX_W + 1;
	localparam int COORD_W    = 14;
	localparam int DIFF_W     = COORD_W + 1;
	localparam int AREA_W     = 30;
	localparam int NEED_W     = 9;
	localparam int CADDR_W    = 2 * IDX_W;

	localparam logic [AREA_W-1:0] NO_AREA  = AREA_W'(1000000000);
	localparam logic [DIFF_W-1:0] MARGIN   = DIFF_W'(2);
	localparam logic [CNT_W-1:0]  MAX_CNT  = CNT_W'(MAX_POINTS);

	// Register index on the configuration port.
	localparam logic REG_NEEDED_COUNT = 1'b0;

	typedef struct packed {
		logic               acc;
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
		logic               last;
	} pt_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_CLR,
		ST_RK_I,
		ST_RK_LD,
		ST_RK_CMP,
		ST_RK_WR,
		ST_RK_INC,
		ST_PF_RD,
		ST_PF_WR,
		ST_SW_Y0,
		ST_SW_Y1,
		ST_SW_Y2,
		ST_CC_A,
		ST_CC_B,
		ST_CC_C,
		ST_AR_A,
		ST_AR_B,
		ST_AR_C,
		ST_AR_D,
		ST_NXT,
		ST_DONE
	} state_t;

endpackage

>>> sv/marea_ram.sv
// ----------------------------------------------------------------------------
// marea_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module marea_ram #(
	parameter int DW = 8,
	parameter int AW = 8
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] wa,
	input  logic [DW-1:0] wd,
	input  logic [AW-1:0] ra,
	output logic [DW-1:0] rd
);

	logic [DW-1:0] mem [(1 << AW)];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
		rd <= mem[ra];
	end

endmodule

>>> sv/marea_core.sv
// ----------------------------------------------------------------------------
// marea_core
// Point store, counting sort with ranking, count grid and the window sweep.
// ----------------------------------------------------------------------------
module marea_core (
	input  logic                              clk,
	input  logic                              arst_n,
	input  marea_pkg::pt_t                    pt,
	input  logic [marea_pkg::NEED_W-1:0]      need,
	input  logic                              res_ready,
	output logic                              busy,
	output logic                              done,
	output logic [marea_pkg::AREA_W-1:0]      area
);

	localparam int IW = marea_pkg::IDX_W;
	localparam int CW = marea_pkg::CNT_W;
	localparam int XW = marea_pkg::COORD_W;
	localparam int DW = marea_pkg::DIFF_W;
	localparam int AW = marea_pkg::AREA_W;

	marea_pkg::state_t state_q, state_d;

	logic [CW-1:0] n_q, i_q, j_q, rx_q, ry_q, posx_q, posy_q, sum_q;
	logic [CW-1:0] lo_q, hi_q, end_q, start_q, held_q, chi_q;
	logic [IW-1:0] col_q;
	logic          shrink_q;
	logic [XW-1:0] xi_q, yi_q, yhi_q, xe_q;
	logic [DW-1:0] dy_q;
	logic [AW-1:0] prod_q, best_q;

	// Memory ports
	logic          p_we;
	logic [IW-1:0] p_wa, p_ra;
	logic [XW-1:0] px_rd, py_rd;
	logic          s_we;
	logic [IW-1:0] sx_wa, sy_wa, sx_ra, sy_ra;
	logic [XW-1:0] sx_rd, sy_rd;
	logic               c_we;
	logic [2*IW-1:0]    c_wa, c_ra;
	logic [CW-1:0]      c_wd, c_rd;

	logic [CW-1:0] need_eff, lo_v, cc, held_add, held_sub, sum_new;
	logic [CW-1:0] j_inc, i_inc, end_inc, hi_inc, lo_inc, lo_m1, start_m1;
	logic [DW-1:0] dx;
	logic          xlt, xpos, ylt, ypos;

	marea_ram #(.DW(XW), .AW(IW)) u_px (
		.clk(clk), .we(p_we), .wa(p_wa), .wd(pt.x), .ra(p_ra), .rd(px_rd)
	);
	marea_ram #(.DW(XW), .AW(IW)) u_py (
		.clk(clk), .we(p_we), .wa(p_wa), .wd(pt.y), .ra(p_ra), .rd(py_rd)
	);
	marea_ram #(.DW(XW), .AW(IW)) u_sx (
		.clk(clk), .we(s_we), .wa(sx_wa), .wd(xi_q), .ra(sx_ra), .rd(sx_rd)
	);
	marea_ram #(.DW(XW), .AW(IW)) u_sy (
		.clk(clk), .we(s_we), .wa(sy_wa), .wd(yi_q), .ra(sy_ra), .rd(sy_rd)
	);
	marea_ram #(.DW(CW), .AW(2*IW)) u_cnt (
		.clk(clk), .we(c_we), .wa(c_wa), .wd(c_wd), .ra(c_ra), .rd(c_rd)
	);

	always_comb begin
		need_eff = (need == '0) ? CW'(1) : CW'(need);
		j_inc    = j_q + CW'(1);
		i_inc    = i_q + CW'(1);
		end_inc  = end_q + CW'(1);
		hi_inc   = hi_q + CW'(1);
		lo_inc   = lo_q + CW'(1);
		lo_m1    = lo_q - CW'(1);
		start_m1 = start_q - CW'(1);
		lo_v     = (lo_q == '0) ? '0 : c_rd;
		cc       = chi_q - lo_v;
		held_add = held_q + cc;
		held_sub = held_q - cc;
		sum_new  = ((j_q == '0) ? '0 : sum_q) + c_rd;
		dx       = DW'(xe_q) - DW'(sx_rd) + marea_pkg::MARGIN;
		xlt      = px_rd < xi_q;
		ylt      = py_rd < yi_q;
		xpos     = xlt || (px_rd == xi_q && j_q < i_q);
		ypos     = ylt || (py_rd == yi_q && j_q < i_q);
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			marea_pkg::ST_IDLE:   if (pt.acc && pt.last) state_d = marea_pkg::ST_CLR;
			marea_pkg::ST_CLR:
				if (j_inc == n_q && i_inc == n_q) state_d = marea_pkg::ST_RK_I;
			marea_pkg::ST_RK_I:   state_d = marea_pkg::ST_RK_LD;
			marea_pkg::ST_RK_LD:  state_d = marea_pkg::ST_RK_CMP;
			marea_pkg::ST_RK_CMP: if (j_inc == n_q) state_d = marea_pkg::ST_RK_WR;
			marea_pkg::ST_RK_WR:  state_d = marea_pkg::ST_RK_INC;
			marea_pkg::ST_RK_INC:
				state_d = (i_inc == n_q) ? marea_pkg::ST_PF_RD : marea_pkg::ST_RK_I;
			marea_pkg::ST_PF_RD:  state_d = marea_pkg::ST_PF_WR;
			marea_pkg::ST_PF_WR:
				state_d = (j_inc == n_q && i_inc == n_q) ? marea_pkg::ST_SW_Y0
				                                         : marea_pkg::ST_PF_RD;
			marea_pkg::ST_SW_Y0:  state_d = marea_pkg::ST_SW_Y1;
			marea_pkg::ST_SW_Y1:  state_d = marea_pkg::ST_SW_Y2;
			marea_pkg::ST_SW_Y2:  state_d = marea_pkg::ST_CC_A;
			marea_pkg::ST_CC_A:   state_d = marea_pkg::ST_CC_B;
			marea_pkg::ST_CC_B:   state_d = marea_pkg::ST_CC_C;
			marea_pkg::ST_CC_C: begin
				if (!shrink_q) begin
					if (held_add >= need_eff)  state_d = marea_pkg::ST_CC_A;
					else if (end_inc == n_q)   state_d = marea_pkg::ST_NXT;
					else                       state_d = marea_pkg::ST_CC_A;
				end else begin
					state_d = (held_sub >= need_eff) ? marea_pkg::ST_CC_A
					                                 : marea_pkg::ST_AR_A;
				end
			end
			marea_pkg::ST_AR_A:   state_d = marea_pkg::ST_AR_B;
			marea_pkg::ST_AR_B:   state_d = marea_pkg::ST_AR_C;
			marea_pkg::ST_AR_C:   state_d = marea_pkg::ST_AR_D;
			marea_pkg::ST_AR_D:
				state_d = (end_inc == n_q) ? marea_pkg::ST_NXT : marea_pkg::ST_CC_A;
			marea_pkg::ST_NXT:
				state_d = (hi_inc == n_q && lo_inc == n_q) ? marea_pkg::ST_DONE
				                                           : marea_pkg::ST_SW_Y0;
			marea_pkg::ST_DONE:   if (res_ready) state_d = marea_pkg::ST_IDLE;
			default:              state_d = marea_pkg::ST_IDLE;
		endcase
	end

	// Memory control
	always_comb begin
		p_we  = 1'b0;
		p_wa  = n_q[IW-1:0];
		p_ra  = '0;
		s_we  = 1'b0;
		sx_wa = posx_q[IW-1:0];
		sy_wa = posy_q[IW-1:0];
		sx_ra = '0;
		sy_ra = '0;
		c_we  = 1'b0;
		c_wa  = {i_q[IW-1:0], j_q[IW-1:0]};
		c_wd  = '0;
		c_ra  = {i_q[IW-1:0], j_q[IW-1:0]};
		unique case (state_q)
			marea_pkg::ST_IDLE:   p_we = pt.acc && (n_q < marea_pkg::MAX_CNT);
			marea_pkg::ST_CLR:    c_we = 1'b1;
			marea_pkg::ST_RK_I:   p_ra = i_q[IW-1:0];
			marea_pkg::ST_RK_LD:  p_ra = '0;
			marea_pkg::ST_RK_CMP: p_ra = j_inc[IW-1:0];
			marea_pkg::ST_RK_WR: begin
				s_we = 1'b1;
				c_ra = {rx_q[IW-1:0], ry_q[IW-1:0]};
			end
			marea_pkg::ST_RK_INC: begin
				c_we = 1'b1;
				c_wa = {rx_q[IW-1:0], ry_q[IW-1:0]};
				c_wd = c_rd + CW'(1);
			end
			marea_pkg::ST_PF_WR: begin
				c_we = 1'b1;
				c_wd = sum_new;
			end
			marea_pkg::ST_SW_Y0:  sy_ra = hi_q[IW-1:0];
			marea_pkg::ST_SW_Y1:  sy_ra = lo_q[IW-1:0];
			marea_pkg::ST_CC_A:   c_ra = {col_q, hi_q[IW-1:0]};
			marea_pkg::ST_CC_B:   c_ra = {col_q, lo_m1[IW-1:0]};
			marea_pkg::ST_AR_A:   sx_ra = end_q[IW-1:0];
			marea_pkg::ST_AR_B:   sx_ra = start_m1[IW-1:0];
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= marea_pkg::ST_IDLE;
			n_q     <= '0;
			best_q  <= marea_pkg::NO_AREA;
		end else begin
			state_q <= state_d;
			if (state_q == marea_pkg::ST_IDLE && pt.acc) begin
				if (n_q < marea_pkg::MAX_CNT) n_q <= n_q + CW'(1);
				if (pt.last) best_q <= marea_pkg::NO_AREA;
			end
			if (state_q == marea_pkg::ST_AR_D && prod_q < best_q) best_q <= prod_q;
			if (state_q == marea_pkg::ST_DONE && res_ready) n_q <= '0;
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			marea_pkg::ST_IDLE: begin
				i_q <= '0;
				j_q <= '0;
			end
			marea_pkg::ST_CLR: begin
				if (j_inc == n_q) begin
					j_q <= '0;
					i_q <= (i_inc == n_q) ? '0 : i_inc;
				end else begin
					j_q <= j_inc;
				end
			end
			marea_pkg::ST_RK_LD: begin
				xi_q   <= px_rd;
				yi_q   <= py_rd;
				j_q    <= '0;
				rx_q   <= '0;
				ry_q   <= '0;
				posx_q <= '0;
				posy_q <= '0;
			end
			marea_pkg::ST_RK_CMP: begin
				rx_q   <= rx_q + CW'(xlt);
				ry_q   <= ry_q + CW'(ylt);
				posx_q <= posx_q + CW'(xpos);
				posy_q <= posy_q + CW'(ypos);
				j_q    <= j_inc;
			end
			marea_pkg::ST_RK_INC: begin
				i_q <= (i_inc == n_q) ? '0 : i_inc;
				j_q <= '0;
			end
			marea_pkg::ST_PF_WR: begin
				sum_q <= sum_new;
				if (j_inc == n_q) begin
					j_q <= '0;
					i_q <= i_inc;
				end else begin
					j_q <= j_inc;
				end
				lo_q <= '0;
				hi_q <= '0;
			end
			marea_pkg::ST_SW_Y1: yhi_q <= sy_rd;
			marea_pkg::ST_SW_Y2: begin
				dy_q     <= DW'(yhi_q) - DW'(sy_rd) + marea_pkg::MARGIN;
				end_q    <= '0;
				start_q  <= '0;
				held_q   <= '0;
				shrink_q <= 1'b0;
				col_q    <= '0;
			end
			marea_pkg::ST_CC_B: chi_q <= c_rd;
			marea_pkg::ST_CC_C: begin
				if (!shrink_q) begin
					held_q <= held_add;
					if (held_add >= need_eff) begin
						shrink_q <= 1'b1;
						col_q    <= start_q[IW-1:0];
					end else begin
						end_q <= end_inc;
						col_q <= end_inc[IW-1:0];
					end
				end else begin
					held_q  <= held_sub;
					start_q <= start_q + CW'(1);
					col_q   <= start_q[IW-1:0] + IW'(1);
				end
			end
			marea_pkg::ST_AR_B: xe_q <= sx_rd;
			marea_pkg::ST_AR_C: prod_q <= AW'(dx) * AW'(dy_q);
			marea_pkg::ST_AR_D: begin
				shrink_q <= 1'b0;
				end_q    <= end_inc;
				col_q    <= end_inc[IW-1:0];
			end
			marea_pkg::ST_NXT: begin
				if (hi_inc == n_q) begin
					lo_q <= lo_inc;
					hi_q <= lo_inc;
				end else begin
					hi_q <= hi_inc;
				end
			end
			default: ;
		endcase
	end

	assign busy = (state_q != marea_pkg::ST_IDLE);
	assign done = (state_q == marea_pkg::ST_DONE) && res_ready;
	assign area = best_q;

endmodule

>>> sv/min_area_rectangle_k_points.sv
// ----------------------------------------------------------------------------
// min_area_rectangle_k_points
// Smallest axis-aligned rectangle area holding at least needed_count points.
// ----------------------------------------------------------------------------
// A set closed by the last flag is processed in phases: the count grid is
// cleared, each point is ranked in x and y, prefix counts are built along y
// for each x column, and a window sweep over every y range finds the smallest
// area. One set at a time: no point is taken while a set is in process.
// Reset clears control state, sets needed_count to 1.
// ----------------------------------------------------------------------------
module min_area_rectangle_k_points (
	input  logic                              clk,
	input  logic                              arst_n,
	// Point input channel
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [marea_pkg::COORD_W-1:0]     x_coord,
	input  logic [marea_pkg::COORD_W-1:0]     y_coord,
	input  logic                              last,
	// Result channel
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [marea_pkg::AREA_W-1:0]      min_area,
	// Configuration port
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [2:0]                        paddr,
	input  logic [31:0]                       pwdata,
	output logic [31:0]                       prdata,
	output logic                              pready
);

	logic [marea_pkg::NEED_W-1:0] need_q;
	logic                         out_valid_q;
	logic [marea_pkg::AREA_W-1:0] min_area_q;
	marea_pkg::pt_t               pt;
	logic                         busy, done, res_ready;
	logic [marea_pkg::AREA_W-1:0] area;

	// The configuration register is written on the access phase of a write
	// transfer. Only word 0 is decoded; other words are ignored.
	assign pready = 1'b1;
	assign prdata = (paddr[2] == marea_pkg::REG_NEEDED_COUNT) ? 32'(need_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			need_q <= marea_pkg::NEED_W'(1);
		end else if (psel && penable && pwrite && pready &&
		             paddr[2] == marea_pkg::REG_NEEDED_COUNT) begin
			need_q <= pwdata[marea_pkg::NEED_W-1:0];
		end
	end

	// Points are taken whenever the core is idle; a finished result waiting in
	// the output register does not hold up loading of the next set.
	assign in_stall = busy;
	assign pt.acc   = in_valid && !busy;
	assign pt.x     = x_coord;
	assign pt.y     = y_coord;
	assign pt.last  = last;

	// The output register may be reloaded in the same cycle that its current
	// transfer completes.
	assign res_ready = !out_valid_q || !out_stall;

	marea_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.pt        (pt),
		.need      (need_q),
		.res_ready (res_ready),
		.busy      (busy),
		.done      (done),
		.area      (area)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (done) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done) begin
			min_area_q <= area;
		end
	end

	assign out_valid = out_valid_q;
	assign min_area  = min_area_q;

endmodule

>>> sv/marea_chk.sv
// ----------------------------------------------------------------------------
// marea_chk
// Port-level checks for the minimum-area rectangle block.
// ----------------------------------------------------------------------------
module marea_chk (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              in_valid,
	input logic                              in_stall,
	input logic                              last,
	input logic                              out_valid,
	input logic                              out_stall,
	input logic [marea_pkg::AREA_W-1:0]      min_area,
	input logic                              pready
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(min_area))
		else $error("stalled result changed");

	a_area_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> min_area <= marea_pkg::NO_AREA)
		else $error("area above the no-result value");

	a_last_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && last |=> in_stall)
		else $error("set not started after last point");

	a_ready: assert property (@(posedge clk) disable iff (!arst_n) pready)
		else $error("configuration port not ready");

endmodule

bind min_area_rectangle_k_points marea_chk u_marea_chk (.*);

>>> tb/sv/min_area_rectangle_k_points_tb.sv
// ----------------------------------------------------------------------------
// min_area_rectangle_k_points_tb
// Drives point sets into the minimum-area rectangle block over a valid/stall
// channel, predicts each set's area in the testbench and checks every result.
// ----------------------------------------------------------------------------
module min_area_rectangle_k_points_tb;

	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		logic [marea_pkg::COORD_W-1:0] x;
		logic [marea_pkg::COORD_W-1:0] y;
		logic                          last;
	} point_item_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [marea_pkg::COORD_W-1:0] x_coord = '0;
	logic [marea_pkg::COORD_W-1:0] y_coord = '0;
	logic last = 1'b0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [marea_pkg::AREA_W-1:0] min_area;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [2:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	always #4 clk = ~clk;

	min_area_rectangle_k_points DUT (.*);

	// Items waiting for the driver and areas waiting for the monitor.
	point_item_t pending_points[$];
	logic [marea_pkg::AREA_W-1:0] expected_areas[$];

	// Predictor copy of the point set and of the configuration.
	int unsigned need_setting = 1;
	int unsigned set_x[$];
	int unsigned set_y[$];

	int errors = 0;
	int results_seen = 0;
	int points_sent = 0;
	int idle_cycles = 0;
	bit stim_done = 1'b0;
	bit timed_out = 1'b0;
	// Transfers completed at the last rising edge, seen by the drivers.
	bit in_accepted = 1'b0;
	bit out_accepted = 1'b0;

	// Rank of a value is the count of values strictly smaller; with a sorted
	// copy that is the index of the first occurrence.
	function automatic int first_index(int unsigned v[$], int unsigned val);
		foreach (v[k]) if (v[k] == val) return k;
		return v.size() - 1;
	endfunction

	// Computes the area for the collected set the same way the block does:
	// per-column prefix counts along y and a two-pointer window along x.
	function automatic logic [marea_pkg::AREA_W-1:0] enclosing_area();
		int unsigned n, need, best, sx[$], sy[$], dy, dx, held, start, ar, c;
		int unsigned cnt[256][256];
		n = set_x.size();
		need = (need_setting == 0) ? 1 : need_setting;
		best = 1000000000;
		if (n == 0) return marea_pkg::AREA_W'(best);
		for (int i = 0; i < n; i++) for (int j = 0; j < n; j++) cnt[i][j] = 0;
		sx = set_x; sy = set_y;
		sx.sort(); sy.sort();
		for (int i = 0; i < n; i++)
			cnt[first_index(sx, set_x[i])][first_index(sy, set_y[i])]++;
		for (int j = 1; j < n; j++)
			for (int i = 0; i < n; i++) cnt[i][j] += cnt[i][j-1];
		for (int lo = 0; lo < n; lo++) begin
			for (int hi = lo; hi < n; hi++) begin
				dy = sy[hi] - sy[lo] + 2;
				start = 0; held = 0;
				for (int e = 0; e < n; e++) begin
					held += (lo == 0) ? cnt[e][hi] : cnt[e][hi] - cnt[e][lo-1];
					if (held >= need) begin
						while (held >= need && start <= e) begin
							c = (lo == 0) ? cnt[start][hi] : cnt[start][hi] - cnt[start][lo-1];
							held -= c;
							start++;
						end
						dx = sx[e] - sx[start-1] + 2;
						ar = dx * dy;
						if (ar < best) best = ar;
					end
				end
			end
		end
		return marea_pkg::AREA_W'(best);
	endfunction

	// Queues one point and updates the prediction; points beyond the store
	// size are dropped, but a last flag on them still closes the set.
	task automatic add_point(int unsigned x, int unsigned y, bit is_last);
		point_item_t p;
		p.x = marea_pkg::COORD_W'(x);
		p.y = marea_pkg::COORD_W'(y);
		p.last = is_last;
		pending_points.push_back(p);
		if (set_x.size() < marea_pkg::MAX_POINTS) begin
			set_x.push_back(x);
			set_y.push_back(y);
		end
		if (is_last) begin
			expected_areas.push_back(enclosing_area());
			set_x.delete();
			set_y.delete();
		end
	endtask

	// Random set of n points, optionally with clustered coordinates so that ranks tie.
	task automatic add_random_set(int unsigned n, bit clustered);
		int unsigned x, y;
		for (int i = 0; i < n; i++) begin
			if (clustered) begin
				x = $urandom_range(0, 7); y = $urandom_range(0, 7);
			end else begin
				x = $urandom_range(0, 16383); y = $urandom_range(0, 16383);
			end
			add_point(x, y, i == n - 1);
		end
	endtask

	// Waits until the block has drained every queued point and result, then
	// lets the tail of the sweep settle before the register is touched.
	task automatic wait_drained();
		while (pending_points.size() != 0 || expected_areas.size() != 0 || in_valid)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	// Two-phase write on the configuration port, changed at falling edges.
	task automatic write_need(int unsigned val);
		@(negedge clk);
		psel <= 1'b1; pwrite <= 1'b1; paddr <= 3'(4 * marea_pkg::REG_NEEDED_COUNT);
		pwdata <= val;
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
		need_setting = val & 9'h1FF;
	endtask

	// Driver: at each falling edge either holds a transfer that was not taken
	// at the last rising edge, or after a random gap presents the next point.
	int send_gap = 0;
	always @(negedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_accepted) begin
				// Payload held while the block stalls.
			end else if (send_gap > 0) begin
				in_valid <= 1'b0;
				send_gap <= send_gap - 1;
			end else if (pending_points.size() != 0) begin
				point_item_t p;
				p = pending_points.pop_front();
				in_valid <= 1'b1;
				x_coord <= p.x; y_coord <= p.y; last <= p.last;
				send_gap <= $urandom_range(0, 3);
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// The random stall draw happens per accepted result.
	int stall_left = 0;
	always @(negedge clk) begin
		if (arst_n) begin
			if (out_accepted) stall_left = $urandom_range(0, 3);
			if (stall_left > 0) begin
				out_stall <= 1'b1;
				stall_left = stall_left - 1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// Monitor: compares each accepted result with the oldest expectation and
	// keeps the idle watchdog.
	always @(posedge clk) begin
		if (arst_n) begin
			in_accepted <= in_valid && !in_stall;
			out_accepted <= out_valid && !out_stall;
			if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
			else idle_cycles <= idle_cycles + 1;
			if (in_valid && !in_stall) points_sent <= points_sent + 1;
			if (out_valid && !out_stall) begin
				results_seen <= results_seen + 1;
				if (expected_areas.size() == 0) begin
					errors <= errors + 1;
					if (errors < 10) $display("Unexpected result min_area=%0d", min_area);
				end else begin
					logic [marea_pkg::AREA_W-1:0] exp_area;
					exp_area = expected_areas.pop_front();
					if (exp_area !== min_area) begin
						errors <= errors + 1;
						if (errors < 10)
							$display("Mismatch min_area: expected %0d, got %0d",
								exp_area, min_area);
					end
				end
			end
			// Sets stay at six points or fewer, so a sweep ends without a transfer well
			// within the idle limit; the limit leaves ample room.
			if (idle_cycles > 20000) timed_out <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (timed_out) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	initial begin
		int unsigned n;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed part with the reset setting of one point.
		add_point(0, 0, 1'b1);                       // single point
		add_point(16383, 16383, 1'b0);
		add_point(0, 0, 1'b1);                       // extreme corners
		add_point(5, 5, 1'b0);
		add_point(5, 5, 1'b0);
		add_point(5, 9, 1'b1);                       // duplicate points
		wait_drained();

		// Count larger than the first set, where no window qualifies, and equal to the second.
		write_need(4);
		add_point(1, 2, 1'b0);
		add_point(3, 4, 1'b1);
		add_point(10, 10, 1'b0);
		add_point(11, 12, 1'b0);
		add_point(13, 10, 1'b0);
		add_point(10, 14, 1'b1);
		wait_drained();

		// Count of zero acts as one.
		write_need(0);
		add_point(100, 200, 1'b0);
		add_point(16383, 0, 1'b1);
		wait_drained();

		// Largest count with a small set and all pwdata bits toggled.
		write_need(32'hFFFF_FFFF);
		add_random_set(3, 1'b0);
		wait_drained();
		write_need(256);
		add_random_set(2, 1'b0);
		wait_drained();

		// Random phases, mostly small sets with varied counts.
		for (int ph = 0; ph < 8; ph++) begin
			write_need($urandom_range(1, 5));
			for (int s = 0; s < 3; s++) begin
				n = $urandom_range(1, 6);
				add_random_set(n, $urandom_range(0, 1));
			end
			wait_drained();
		end

		stim_done = 1'b1;
		$display("Covered %0d points and %0d sets over several count settings,",
			points_sent, results_seen);
		$display("including ties, extreme corners, a zero count and counts above the set size.");
		if (errors == 0 && expected_areas.size() == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule

>>> filelist.f
sv/marea_pkg.sv
sv/marea_ram.sv
sv/marea_core.sv
sv/min_area_rectangle_k_points.sv
sv/marea_chk.sv
tb/sv/min_area_rectangle_k_points_tb.sv
